// ----- src/snfcs_pkg.sv -----
// ----------------------------------------------------------------------------
// snfcs_pkg
// shared types, opcodes and result row helpers for the spi nor command sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package snfcs_pkg;

  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

  localparam int ADDR_W     = 24;
  localparam int COUNT_W    = 16;
  localparam int PAGE_CNT_W = PAGE_SHIFT + 1;
  localparam int MAX_ROWS   = 8;
  localparam int ROW_IDX_W  = 3;
  localparam int ROW_CNT_W  = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_PROGRAM = 2'd1,
    KIND_FLASH   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    OP_ID          = 4'd0,
    OP_RDSR        = 4'd1,
    OP_WRSR        = 4'd2,
    OP_WREN        = 4'd3,
    OP_WRDI        = 4'd4,
    OP_PROGRAM     = 4'd5,
    OP_READ        = 4'd6,
    OP_SECTOR_ERASE = 4'd7,
    OP_CHIP_ERASE  = 4'd8,
    OP_POWER_DOWN  = 4'd9,
    OP_RELEASE     = 4'd10
  } op_t;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_ID_HI      = 5'd1,
    PH_ID_LO      = 5'd2,
    PH_SR_WAIT    = 5'd3,
    PH_PROG_DATA  = 5'd4,
    PH_PROG_POLL  = 5'd5,
    PH_READ_WAIT  = 5'd6,
    PH_ERASE_PRE  = 5'd7,
    PH_ERASE_POST = 5'd8
  } phase_t;

  localparam logic [7:0] OPC_ID       = 8'h90;
  localparam logic [7:0] OPC_RDSR     = 8'h05;
  localparam logic [7:0] OPC_WRSR     = 8'h01;
  localparam logic [7:0] OPC_WREN     = 8'h06;
  localparam logic [7:0] OPC_WRDI     = 8'h04;
  localparam logic [7:0] OPC_PP       = 8'h02;
  localparam logic [7:0] OPC_READ     = 8'h03;
  localparam logic [7:0] OPC_SE       = 8'h20;
  localparam logic [7:0] OPC_CE       = 8'hC7;
  localparam logic [7:0] OPC_PD       = 8'hB9;
  localparam logic [7:0] OPC_RPD      = 8'hAB;
  localparam logic [7:0] DUMMY_BYTE   = 8'hFF;

  // packed from the lowest bit up: spi_valid first, operation_done last
  typedef struct packed {
    logic        operation_done;
    logic [15:0] device_id;
    logic        id_valid;
    logic [7:0]  read_value;
    logic        read_valid;
    logic        capture_response;
    logic        release_select;
    logic [7:0]  spi_byte;
    logic        spi_valid;
  } row_t;

  typedef struct packed {
    row_t [MAX_ROWS-1:0]  rows;
    logic [ROW_CNT_W-1:0] count;
  } batch_t;

  typedef struct packed {
    logic   load;
    batch_t batch;
  } load_t;

  function automatic row_t spi_row(input logic [7:0] b, input logic rel, input logic cap);
    row_t r;
    r                  = '0;
    r.spi_valid        = 1'b1;
    r.spi_byte         = b;
    r.release_select   = rel;
    r.capture_response = cap;
    return r;
  endfunction

  function automatic row_t done_row();
    row_t r;
    r                = '0;
    r.operation_done = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/snfcs_cmd.sv -----
// ----------------------------------------------------------------------------
// snfcs_cmd
// input register, sequencer state and per-item result batch builder
// ----------------------------------------------------------------------------
`default_nettype none

module snfcs_cmd (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [snfcs_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]                    in_tuser,
  input  wire logic                          can_load,
  output snfcs_pkg::load_t                   load_o
);

  logic                            inq_valid_r;
  logic [1:0]                      inq_kind_r;
  logic [3:0]                      inq_op_r;
  logic [snfcs_pkg::ADDR_W-1:0]    inq_addr_r;
  logic [snfcs_pkg::COUNT_W-1:0]   inq_count_r;
  logic [7:0]                      inq_db_r;

  snfcs_pkg::phase_t               phase_r, phase_nxt;
  logic [3:0]                      op_r, op_nxt;
  logic [snfcs_pkg::ADDR_W-1:0]    addr_r, addr_nxt;
  logic [snfcs_pkg::COUNT_W-1:0]   bl_r, bl_nxt;
  logic [snfcs_pkg::PAGE_CNT_W-1:0] pbl_r, pbl_nxt;
  logic [7:0]                      idh_r, idh_nxt;

  logic                            take;
  snfcs_pkg::batch_t               bt;
  logic [snfcs_pkg::ROW_CNT_W-1:0] n;
  logic                            do_page, do_poll, do_done, end_page;
  logic [snfcs_pkg::ADDR_W-1:0]    ea;
  logic [snfcs_pkg::COUNT_W-1:0]   dec_bl;
  logic [snfcs_pkg::PAGE_CNT_W-1:0] room;

  assign take      = inq_valid_r && can_load;
  assign in_tready = !inq_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_tready) begin
      inq_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      inq_kind_r  <= in_tuser;
      inq_op_r    <= in_tdata[3:0];
      inq_addr_r  <= in_tdata[27:4];
      inq_count_r <= in_tdata[43:28];
      inq_db_r    <= in_tdata[51:44];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= snfcs_pkg::PH_IDLE;
      op_r    <= '0;
      addr_r  <= '0;
      bl_r    <= '0;
      pbl_r   <= '0;
      idh_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      bl_r    <= bl_nxt;
      pbl_r   <= pbl_nxt;
      idh_r   <= idh_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    bl_nxt    = bl_r;
    pbl_nxt   = pbl_r;
    idh_nxt   = idh_r;
    bt        = '0;
    n         = '0;
    do_page   = 1'b0;
    do_poll   = 1'b0;
    do_done   = 1'b0;
    end_page  = (pbl_r <= snfcs_pkg::PAGE_CNT_W'(1));
    dec_bl    = bl_r - snfcs_pkg::COUNT_W'(1);
    ea        = addr_r;
    room      = '0;

    case (inq_kind_r)
      snfcs_pkg::KIND_REQUEST: begin
        if (phase_r == snfcs_pkg::PH_IDLE) begin
          op_nxt = inq_op_r;
          case (inq_op_r)
            snfcs_pkg::OP_ID: begin
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_ID, 1'b0, 1'b0);
              bt.rows[1] = snfcs_pkg::spi_row(8'h00, 1'b0, 1'b0);
              bt.rows[2] = snfcs_pkg::spi_row(8'h00, 1'b0, 1'b0);
              bt.rows[3] = snfcs_pkg::spi_row(8'h00, 1'b0, 1'b0);
              bt.rows[4] = snfcs_pkg::spi_row(snfcs_pkg::DUMMY_BYTE, 1'b0, 1'b1);
              bt.rows[5] = snfcs_pkg::spi_row(snfcs_pkg::DUMMY_BYTE, 1'b1, 1'b1);
              n          = snfcs_pkg::ROW_CNT_W'(6);
              phase_nxt  = snfcs_pkg::PH_ID_HI;
            end
            snfcs_pkg::OP_RDSR: begin
              do_poll   = 1'b1;
              phase_nxt = snfcs_pkg::PH_SR_WAIT;
            end
            snfcs_pkg::OP_WRSR: begin
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_WRSR, 1'b0, 1'b0);
              bt.rows[1] = snfcs_pkg::spi_row(inq_db_r, 1'b1, 1'b0);
              n          = snfcs_pkg::ROW_CNT_W'(2);
              do_done    = 1'b1;
            end
            snfcs_pkg::OP_WREN: begin
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_WREN, 1'b1, 1'b0);
              n          = snfcs_pkg::ROW_CNT_W'(1);
              do_done    = 1'b1;
            end
            snfcs_pkg::OP_WRDI: begin
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_WRDI, 1'b1, 1'b0);
              n          = snfcs_pkg::ROW_CNT_W'(1);
              do_done    = 1'b1;
            end
            snfcs_pkg::OP_POWER_DOWN: begin
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_PD, 1'b1, 1'b0);
              n          = snfcs_pkg::ROW_CNT_W'(1);
              do_done    = 1'b1;
            end
            snfcs_pkg::OP_RELEASE: begin
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_RPD, 1'b1, 1'b0);
              n          = snfcs_pkg::ROW_CNT_W'(1);
              do_done    = 1'b1;
            end
            snfcs_pkg::OP_PROGRAM: begin
              addr_nxt = inq_addr_r;
              bl_nxt   = inq_count_r;
              ea       = inq_addr_r;
              if (inq_count_r == '0) begin
                do_done = 1'b1;
              end else begin
                do_page = 1'b1;
              end
            end
            snfcs_pkg::OP_READ: begin
              addr_nxt   = inq_addr_r;
              bl_nxt     = inq_count_r;
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_READ, 1'b0, 1'b0);
              bt.rows[1] = snfcs_pkg::spi_row(inq_addr_r[23:16], 1'b0, 1'b0);
              bt.rows[2] = snfcs_pkg::spi_row(inq_addr_r[15:8], 1'b0, 1'b0);
              bt.rows[3] = snfcs_pkg::spi_row(inq_addr_r[7:0], inq_count_r == '0, 1'b0);
              if (inq_count_r == '0) begin
                n       = snfcs_pkg::ROW_CNT_W'(4);
                do_done = 1'b1;
              end else begin
                bt.rows[4] = snfcs_pkg::spi_row(snfcs_pkg::DUMMY_BYTE,
                                                inq_count_r == snfcs_pkg::COUNT_W'(1), 1'b1);
                n          = snfcs_pkg::ROW_CNT_W'(5);
                phase_nxt  = snfcs_pkg::PH_READ_WAIT;
              end
            end
            snfcs_pkg::OP_SECTOR_ERASE, snfcs_pkg::OP_CHIP_ERASE: begin
              // sector index to byte address, wrapping in 24 bits
              addr_nxt   = snfcs_pkg::ADDR_W'(inq_addr_r << snfcs_pkg::SECTOR_SHIFT);
              bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_WREN, 1'b1, 1'b0);
              n          = snfcs_pkg::ROW_CNT_W'(1);
              do_poll    = 1'b1;
              phase_nxt  = snfcs_pkg::PH_ERASE_PRE;
            end
            default: begin
              do_done = 1'b1;
            end
          endcase
        end
      end
      snfcs_pkg::KIND_PROGRAM: begin
        if (phase_r == snfcs_pkg::PH_PROG_DATA) begin
          bt.rows[0] = snfcs_pkg::spi_row(inq_db_r, end_page, 1'b0);
          n          = snfcs_pkg::ROW_CNT_W'(1);
          addr_nxt   = addr_r + snfcs_pkg::ADDR_W'(1);
          bl_nxt     = dec_bl;
          pbl_nxt    = end_page ? '0 : pbl_r - snfcs_pkg::PAGE_CNT_W'(1);
          if (end_page) begin
            do_poll   = 1'b1;
            phase_nxt = snfcs_pkg::PH_PROG_POLL;
          end
        end
      end
      snfcs_pkg::KIND_FLASH: begin
        case (phase_r)
          snfcs_pkg::PH_ID_HI: begin
            idh_nxt   = inq_db_r;
            phase_nxt = snfcs_pkg::PH_ID_LO;
          end
          snfcs_pkg::PH_ID_LO: begin
            bt.rows[0].id_valid       = 1'b1;
            bt.rows[0].device_id      = {idh_r, inq_db_r};
            bt.rows[0].operation_done = 1'b1;
            n                         = snfcs_pkg::ROW_CNT_W'(1);
            phase_nxt                 = snfcs_pkg::PH_IDLE;
          end
          snfcs_pkg::PH_SR_WAIT: begin
            bt.rows[0].read_valid     = 1'b1;
            bt.rows[0].read_value     = inq_db_r;
            bt.rows[0].operation_done = 1'b1;
            n                         = snfcs_pkg::ROW_CNT_W'(1);
            phase_nxt                 = snfcs_pkg::PH_IDLE;
          end
          snfcs_pkg::PH_PROG_POLL: begin
            if (inq_db_r[0]) begin
              do_poll = 1'b1;
            end else if (bl_r == '0) begin
              do_done = 1'b1;
            end else begin
              do_page = 1'b1;
            end
          end
          snfcs_pkg::PH_READ_WAIT: begin
            bt.rows[0].read_valid = 1'b1;
            bt.rows[0].read_value = inq_db_r;
            n                     = snfcs_pkg::ROW_CNT_W'(1);
            addr_nxt              = addr_r + snfcs_pkg::ADDR_W'(1);
            bl_nxt                = dec_bl;
            if (dec_bl == '0) begin
              bt.rows[0].operation_done = 1'b1;
              phase_nxt                 = snfcs_pkg::PH_IDLE;
            end else begin
              bt.rows[1] = snfcs_pkg::spi_row(snfcs_pkg::DUMMY_BYTE,
                                              dec_bl == snfcs_pkg::COUNT_W'(1), 1'b1);
              n          = snfcs_pkg::ROW_CNT_W'(2);
            end
          end
          snfcs_pkg::PH_ERASE_PRE: begin
            do_poll = 1'b1;
            if (!inq_db_r[0]) begin
              if (op_r == snfcs_pkg::OP_CHIP_ERASE) begin
                bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_CE, 1'b1, 1'b0);
                n          = snfcs_pkg::ROW_CNT_W'(1);
              end else begin
                bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_SE, 1'b0, 1'b0);
                bt.rows[1] = snfcs_pkg::spi_row(addr_r[23:16], 1'b0, 1'b0);
                bt.rows[2] = snfcs_pkg::spi_row(addr_r[15:8], 1'b0, 1'b0);
                bt.rows[3] = snfcs_pkg::spi_row(addr_r[7:0], 1'b1, 1'b0);
                n          = snfcs_pkg::ROW_CNT_W'(4);
              end
              phase_nxt = snfcs_pkg::PH_ERASE_POST;
            end
          end
          snfcs_pkg::PH_ERASE_POST: begin
            if (inq_db_r[0]) begin
              do_poll = 1'b1;
            end else begin
              do_done = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // page start: write enable, page program and address, bounded at the page edge
    if (do_page) begin
      room = snfcs_pkg::PAGE_CNT_W'(snfcs_pkg::PAGE_BYTES)
           - {1'b0, ea[snfcs_pkg::PAGE_SHIFT-1:0]};
      if (bl_nxt < snfcs_pkg::COUNT_W'(room)) begin
        pbl_nxt = bl_nxt[snfcs_pkg::PAGE_CNT_W-1:0];
      end else begin
        pbl_nxt = room;
      end
      bt.rows[0] = snfcs_pkg::spi_row(snfcs_pkg::OPC_WREN, 1'b1, 1'b0);
      bt.rows[1] = snfcs_pkg::spi_row(snfcs_pkg::OPC_PP, 1'b0, 1'b0);
      bt.rows[2] = snfcs_pkg::spi_row(ea[23:16], 1'b0, 1'b0);
      bt.rows[3] = snfcs_pkg::spi_row(ea[15:8], 1'b0, 1'b0);
      bt.rows[4] = snfcs_pkg::spi_row(ea[7:0], 1'b0, 1'b0);
      n          = snfcs_pkg::ROW_CNT_W'(5);
      phase_nxt  = snfcs_pkg::PH_PROG_DATA;
    end

    // status poll frame always closes the batch
    if (do_poll) begin
      bt.rows[n[snfcs_pkg::ROW_IDX_W-1:0]] = snfcs_pkg::spi_row(snfcs_pkg::OPC_RDSR, 1'b0, 1'b0);
      n = n + snfcs_pkg::ROW_CNT_W'(1);
      bt.rows[n[snfcs_pkg::ROW_IDX_W-1:0]] =
        snfcs_pkg::spi_row(snfcs_pkg::DUMMY_BYTE, 1'b1, 1'b1);
      n = n + snfcs_pkg::ROW_CNT_W'(1);
    end

    if (do_done) begin
      bt.rows[n[snfcs_pkg::ROW_IDX_W-1:0]] = snfcs_pkg::done_row();
      n         = n + snfcs_pkg::ROW_CNT_W'(1);
      phase_nxt = snfcs_pkg::PH_IDLE;
    end

    bt.count     = n;
    load_o.load  = take;
    load_o.batch = bt;
  end

endmodule

`default_nettype wire

// ----- src/snfcs_out.sv -----
// ----------------------------------------------------------------------------
// snfcs_out
// result batch register, hands out one result row per cycle while out_tready is high
// ----------------------------------------------------------------------------
`default_nettype none

module snfcs_out (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire snfcs_pkg::load_t                 load_i,
  output logic                                  can_load,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [snfcs_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                  out_tlast
);

  snfcs_pkg::row_t [snfcs_pkg::MAX_ROWS-1:0] rows_r;
  logic [snfcs_pkg::ROW_CNT_W-1:0]           cnt_r;
  logic [snfcs_pkg::ROW_IDX_W-1:0]           idx_r;
  logic                                      finishing;
  snfcs_pkg::row_t                           row;

  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = ({1'b0, idx_r} == cnt_r - snfcs_pkg::ROW_CNT_W'(1));
  assign finishing  = out_tvalid && out_tready && out_tlast;
  assign can_load   = !out_tvalid || finishing;
  assign row        = rows_r[idx_r];
  assign out_tdata  = {(snfcs_pkg::OUT_DATA_W - $bits(snfcs_pkg::row_t))'(0), row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load_i.load) begin
      cnt_r <= load_i.batch.count;
      idx_r <= '0;
    end else if (finishing) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (out_tvalid && out_tready) begin
      idx_r <= idx_r + snfcs_pkg::ROW_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_i.load) begin
      rows_r <= load_i.batch.rows;
    end
  end

endmodule

`default_nettype wire

// ----- src/spi_nor_flash_command_sequencer.sv -----
// order: an accepted item is registered in the input register and decoded from there; its
//   result batch is loaded into the result buffer register when that is free, which offers the first result item
// throughput: one input item per cycle while the result buffer can take a batch; an item with
//   n result items holds the buffer until its last row leaves, one per cycle with out_tready high
// reset: rst_n low at a clock edge clears the sequencer to idle and drops queued items
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// turns host flash operations into spi byte frames for a 24-bit-address nor flash
// ----------------------------------------------------------------------------
`default_nettype none

module spi_nor_flash_command_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input items
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // operation[3:0], start_address[27:4], byte_count[43:28], data_byte[51:44]
  input  wire logic [snfcs_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[1:0]
  input  wire logic [1:0]                       in_tuser,
  // result items
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // spi_valid[0], spi_byte[8:1], release_select[9], capture_response[10],
  // read_valid[11], read_value[19:12], id_valid[20], device_id[36:21],
  // operation_done[37]
  output logic [snfcs_pkg::OUT_DATA_W-1:0]      out_tdata,
  // last result item caused by one input item
  output logic                                  out_tlast
);

  // batch handoff from the decoder to the result buffer
  snfcs_pkg::load_t load;
  logic             can_load;

  // input register, sequencer phase and address/count state, batch builder
  snfcs_cmd u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .can_load  (can_load),
    .load_o    (load)
  );

  // result buffer: takes a new batch when empty or in the cycle its last row leaves
  snfcs_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- src/snfcs_checker.sv -----
// ----------------------------------------------------------------------------
// snfcs_checker
// port-level checks on the result stream of the command sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module snfcs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [snfcs_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                             out_tlast
);

  // stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // a spi byte row never also reports completion
  a_spi_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[37]))
    else $error("spi byte and done in one item");

  // read data and device id never share an item
  a_read_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[11] && out_tdata[20]))
    else $error("read and id in one item");

  // a captured byte is always a dummy byte shifted out
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[0] && (out_tdata[8:1] == snfcs_pkg::DUMMY_BYTE))
    else $error("capture without dummy byte");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (.*);

`default_nettype wire

// ----- test/tb_spi_nor_flash_command_sequencer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_nor_flash_command_sequencer
// self-checking bench: a directed table, then flash dialogues built around the
// predicted sequencer phase, each result item checked field by field
// ----------------------------------------------------------------------------

module tb_spi_nor_flash_command_sequencer;

  // kind value the block has no meaning for, and an opcode slot with no operation
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [3:0] OP_UNUSED   = 4'd15;

  localparam int TOTAL_ITEMS    = 380;    // input item budget for the whole run
  localparam int LONG_OP_ITEMS  = 320;    // room a long program or read needs to finish
  localparam int BACKLOG_AT     = 150;    // accepted items before the long output hold-off
  localparam int BACKLOG_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 24;
  localparam int REPORT_LIMIT   = 10;

  // one expected result item: the packed row plus its tlast
  typedef struct packed {
    logic            last;
    snfcs_pkg::row_t row;
  } seq_row_t;

  // one row of the directed table; n_typed < 0 means the predictor decides
  typedef struct {
    logic [1:0]      kind;
    logic [3:0]      op;
    logic [23:0]     addr;
    logic [15:0]     cnt;
    logic [7:0]      db;
    int              n_typed;
    snfcs_pkg::row_t typed [3];
  } probe_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [snfcs_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic [1:0]                       in_tuser  = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [snfcs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             out_tlast;

  spi_nor_flash_command_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reset held low at the start, released once
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // hard stop for a hung run
  initial begin
    #30_000_000;
    $display("FAIL spi_nor_flash_command_sequencer");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sequencer predictor state
  // --------------------------------------------------------------------------
  snfcs_pkg::phase_t seq_phase   = snfcs_pkg::PH_IDLE;
  logic [3:0]        seq_op      = '0;
  logic [23:0]       seq_addr    = '0;
  logic [15:0]       bytes_to_go = '0;
  logic [8:0]        page_room   = '0;
  logic [7:0]        id_manuf    = '0;

  snfcs_pkg::row_t burst [$];          // result rows caused by the item just accepted
  seq_row_t        spi_rows_due [$];   // expected result items, oldest first

  int items_accepted = 0;
  int results_seen   = 0;
  int fail_count     = 0;
  int pages_opened   = 0;
  int busy_repolls   = 0;
  int ops_started    = 0;
  bit sender_steady  = 1'b0;
  bit backlog_done   = 1'b0;

  function automatic snfcs_pkg::row_t mosi_row(input logic [7:0] b, input logic rel,
                                               input logic cap);
    snfcs_pkg::row_t r;
    r = '0;
    r.spi_valid        = 1'b1;
    r.spi_byte         = b;
    r.release_select   = rel;
    r.capture_response = cap;
    return r;
  endfunction

  function automatic snfcs_pkg::row_t host_row(input logic rd_v, input logic [7:0] rd,
                                               input logic id_v, input logic [15:0] id,
                                               input logic done);
    snfcs_pkg::row_t r;
    r = '0;
    r.read_valid     = rd_v;
    r.read_value     = rd;
    r.id_valid       = id_v;
    r.device_id      = id;
    r.operation_done = done;
    return r;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic rel, input logic cap);
    burst.push_back(mosi_row(b, rel, cap));
  endtask

  task automatic put_done();
    burst.push_back(host_row(1'b0, '0, 1'b0, '0, 1'b1));
    seq_phase = snfcs_pkg::PH_IDLE;
  endtask

  // address goes out msb first, chip select optionally released on the low byte
  task automatic put_addr(input logic [23:0] a, input logic rel_last);
    put_byte(a[23:16], 1'b0, 1'b0);
    put_byte(a[15:8], 1'b0, 1'b0);
    put_byte(a[7:0], rel_last, 1'b0);
  endtask

  task automatic put_poll();
    put_byte(snfcs_pkg::OPC_RDSR, 1'b0, 1'b0);
    put_byte(snfcs_pkg::DUMMY_BYTE, 1'b1, 1'b1);
  endtask

  // write enable, page program opcode and address; the page ends at the boundary
  task automatic open_page();
    int room;
    room = snfcs_pkg::PAGE_BYTES - (seq_addr % snfcs_pkg::PAGE_BYTES);
    page_room = (bytes_to_go < room) ? 9'(bytes_to_go) : 9'(room);
    put_byte(snfcs_pkg::OPC_WREN, 1'b1, 1'b0);
    put_byte(snfcs_pkg::OPC_PP, 1'b0, 1'b0);
    put_addr(seq_addr, 1'b0);
    seq_phase = snfcs_pkg::PH_PROG_DATA;
    pages_opened++;
  endtask

  task automatic put_slot();
    put_byte(snfcs_pkg::DUMMY_BYTE, bytes_to_go == 16'd1, 1'b1);
  endtask

  task automatic launch_op(input logic [3:0] op, input logic [23:0] addr,
                           input logic [15:0] cnt, input logic [7:0] db);
    seq_op = op;
    ops_started++;
    case (op)
      snfcs_pkg::OP_ID: begin
        put_byte(snfcs_pkg::OPC_ID, 1'b0, 1'b0);
        put_addr(24'h000000, 1'b0);
        put_byte(snfcs_pkg::DUMMY_BYTE, 1'b0, 1'b1);
        put_byte(snfcs_pkg::DUMMY_BYTE, 1'b1, 1'b1);
        seq_phase = snfcs_pkg::PH_ID_HI;
      end
      snfcs_pkg::OP_RDSR: begin
        put_poll();
        seq_phase = snfcs_pkg::PH_SR_WAIT;
      end
      snfcs_pkg::OP_WRSR: begin
        put_byte(snfcs_pkg::OPC_WRSR, 1'b0, 1'b0);
        put_byte(db, 1'b1, 1'b0);
        put_done();
      end
      snfcs_pkg::OP_WREN: begin
        put_byte(snfcs_pkg::OPC_WREN, 1'b1, 1'b0);
        put_done();
      end
      snfcs_pkg::OP_WRDI: begin
        put_byte(snfcs_pkg::OPC_WRDI, 1'b1, 1'b0);
        put_done();
      end
      snfcs_pkg::OP_POWER_DOWN: begin
        put_byte(snfcs_pkg::OPC_PD, 1'b1, 1'b0);
        put_done();
      end
      snfcs_pkg::OP_RELEASE: begin
        put_byte(snfcs_pkg::OPC_RPD, 1'b1, 1'b0);
        put_done();
      end
      snfcs_pkg::OP_PROGRAM: begin
        seq_addr    = addr;
        bytes_to_go = cnt;
        if (cnt == 16'd0) put_done();
        else open_page();
      end
      snfcs_pkg::OP_READ: begin
        seq_addr    = addr;
        bytes_to_go = cnt;
        put_byte(snfcs_pkg::OPC_READ, 1'b0, 1'b0);
        put_addr(addr, cnt == 16'd0);
        if (cnt == 16'd0) begin
          put_done();
        end else begin
          put_slot();
          seq_phase = snfcs_pkg::PH_READ_WAIT;
        end
      end
      snfcs_pkg::OP_SECTOR_ERASE, snfcs_pkg::OP_CHIP_ERASE: begin
        // sector index scaled to a byte address, wrapping in 24 bits
        seq_addr = 24'(longint'(addr) * snfcs_pkg::SECTOR_BYTES);
        put_byte(snfcs_pkg::OPC_WREN, 1'b1, 1'b0);
        put_poll();
        seq_phase = snfcs_pkg::PH_ERASE_PRE;
      end
      default: put_done();
    endcase
  endtask

  task automatic take_flash(input logic [7:0] b);
    case (seq_phase)
      snfcs_pkg::PH_ID_HI: begin
        id_manuf  = b;
        seq_phase = snfcs_pkg::PH_ID_LO;
      end
      snfcs_pkg::PH_ID_LO: begin
        burst.push_back(host_row(1'b0, '0, 1'b1, {id_manuf, b}, 1'b1));
        seq_phase = snfcs_pkg::PH_IDLE;
      end
      snfcs_pkg::PH_SR_WAIT: begin
        burst.push_back(host_row(1'b1, b, 1'b0, '0, 1'b1));
        seq_phase = snfcs_pkg::PH_IDLE;
      end
      snfcs_pkg::PH_PROG_POLL: begin
        if (b[0]) begin
          put_poll();
          busy_repolls++;
        end else if (bytes_to_go == 16'd0) begin
          put_done();
        end else begin
          open_page();
        end
      end
      snfcs_pkg::PH_READ_WAIT: begin
        seq_addr    = seq_addr + 24'd1;
        bytes_to_go = bytes_to_go - 16'd1;
        if (bytes_to_go == 16'd0) begin
          burst.push_back(host_row(1'b1, b, 1'b0, '0, 1'b1));
          seq_phase = snfcs_pkg::PH_IDLE;
        end else begin
          burst.push_back(host_row(1'b1, b, 1'b0, '0, 1'b0));
          put_slot();
        end
      end
      snfcs_pkg::PH_ERASE_PRE: begin
        if (b[0]) begin
          put_poll();
          busy_repolls++;
        end else begin
          if (seq_op == snfcs_pkg::OP_CHIP_ERASE) begin
            put_byte(snfcs_pkg::OPC_CE, 1'b1, 1'b0);
          end else begin
            put_byte(snfcs_pkg::OPC_SE, 1'b0, 1'b0);
            put_addr(seq_addr, 1'b1);
          end
          put_poll();
          seq_phase = snfcs_pkg::PH_ERASE_POST;
        end
      end
      snfcs_pkg::PH_ERASE_POST: begin
        if (b[0]) begin
          put_poll();
          busy_repolls++;
        end else begin
          put_done();
        end
      end
      default: ;   // nothing awaited, byte dropped
    endcase
  endtask

  // program data byte; the last byte of a page closes the frame and starts polling
  task automatic take_data(input logic [7:0] db);
    logic page_end;
    page_end = (page_room <= 9'd1);
    put_byte(db, page_end, 1'b0);
    seq_addr    = seq_addr + 24'd1;
    bytes_to_go = bytes_to_go - 16'd1;
    page_room   = page_end ? 9'd0 : page_room - 9'd1;
    if (page_end) begin
      put_poll();
      seq_phase = snfcs_pkg::PH_PROG_POLL;
    end
  endtask

  // fills burst with the result rows of one accepted item and advances the state
  task automatic predict_frames(input logic [1:0] kind, input logic [3:0] op,
                                input logic [23:0] addr, input logic [15:0] cnt,
                                input logic [7:0] db);
    burst.delete();
    case (kind)
      snfcs_pkg::KIND_REQUEST: if (seq_phase == snfcs_pkg::PH_IDLE) launch_op(op, addr, cnt, db);
      snfcs_pkg::KIND_PROGRAM: if (seq_phase == snfcs_pkg::PH_PROG_DATA) take_data(db);
      snfcs_pkg::KIND_FLASH:   take_flash(db);
      default: ;
    endcase
  endtask

  // queues burst, or the typed rows of a table entry, with tlast on the final row
  task automatic expect_rows(input int n_typed, input snfcs_pkg::row_t t0 = '0,
                             input snfcs_pkg::row_t t1 = '0, input snfcs_pkg::row_t t2 = '0);
    seq_row_t e;
    if (n_typed >= 0) begin
      burst.delete();
      if (n_typed > 0) burst.push_back(t0);
      if (n_typed > 1) burst.push_back(t1);
      if (n_typed > 2) burst.push_back(t2);
    end
    foreach (burst[i]) begin
      e.row  = burst[i];
      e.last = (i == burst.size() - 1);
      spi_rows_due.push_back(e);
    end
  endtask

  function automatic int pick_gap(input bit steady);
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one item offered on the input side; valid stays high across back-to-back items
  task automatic offer_item(input logic [1:0] kind, input logic [3:0] op,
                            input logic [23:0] addr, input logic [15:0] cnt,
                            input logic [7:0] db);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, db, cnt, addr, op};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    items_accepted++;
  endtask

  // random item shaped by the predicted phase: mostly the reply the flash dialogue
  // wants next, with some noise of any kind and any fields
  task automatic choose_item(output logic [1:0] kind, output logic [3:0] op,
                             output logic [23:0] addr, output logic [15:0] cnt,
                             output logic [7:0] db);
    bit long_ok;
    // long transfers only while they can finish well inside the item budget
    long_ok = (items_accepted + LONG_OP_ITEMS < TOTAL_ITEMS);
    kind = snfcs_pkg::KIND_REQUEST;
    op   = 4'($urandom);
    addr = 24'($urandom);
    cnt  = 16'($urandom);
    db   = 8'($urandom);
    if ($urandom_range(0, 99) < 8) begin
      // noise: any kind, any fields, whatever the phase
      kind = 2'($urandom_range(0, 3));
    end else begin
      case (seq_phase)
        snfcs_pkg::PH_IDLE: begin
          if ($urandom_range(0, 19) == 0) op = 4'($urandom_range(11, 15));
          else if ($urandom_range(0, 99) < 30) op = snfcs_pkg::OP_PROGRAM;
          else op = 4'($urandom_range(0, 10));
          case ($urandom_range(0, 3))
            0: addr = 24'($urandom);
            // a few bytes short of a page boundary
            1: addr = {16'($urandom), 8'(snfcs_pkg::PAGE_BYTES - $urandom_range(1, 6))};
            // top of the address space, wraps to zero
            2: addr = 24'hFFFFFF - 24'($urandom_range(0, 300));
            default: addr = 24'($urandom_range(0, 1023));
          endcase
          if (op == snfcs_pkg::OP_PROGRAM)
            cnt = (long_ok && $urandom_range(0, 24) == 0) ? 16'($urandom_range(200, 300))
                                                          : 16'($urandom_range(0, 24));
          else if (op == snfcs_pkg::OP_READ)
            cnt = (long_ok && $urandom_range(0, 29) == 0) ? 16'($urandom_range(100, 300))
                                                          : 16'($urandom_range(0, 12));
        end
        snfcs_pkg::PH_PROG_DATA: kind = snfcs_pkg::KIND_PROGRAM;
        default: begin
          kind = snfcs_pkg::KIND_FLASH;
          // polled status comes back busy about a quarter of the time
          if (seq_phase inside {snfcs_pkg::PH_PROG_POLL, snfcs_pkg::PH_ERASE_PRE,
                                snfcs_pkg::PH_ERASE_POST})
            db[0] = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold-off to fill the block
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    bit steady;
    steady = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!backlog_done && items_accepted >= BACKLOG_AT) begin
        out_tready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
        backlog_done = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) steady = !steady;
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = pick_gap(steady);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // every accepted result item against the oldest expectation
  always @(posedge clk) begin : result_check
    seq_row_t want;
    snfcs_pkg::row_t seen;
    string bad;
    if (rst_n && out_tvalid && out_tready) begin
      seen = snfcs_pkg::row_t'(out_tdata[$bits(snfcs_pkg::row_t)-1:0]);
      results_seen++;
      if (spi_rows_due.size() == 0) begin
        note_failure($sformatf("result item %h with nothing expected", out_tdata));
      end else begin
        want = spi_rows_due.pop_front();
        bad  = "";
        if (seen.spi_valid !== want.row.spi_valid) bad = {bad, " spi_valid"};
        if (seen.spi_byte !== want.row.spi_byte) bad = {bad, " spi_byte"};
        if (seen.release_select !== want.row.release_select) bad = {bad, " release_select"};
        if (seen.capture_response !== want.row.capture_response)
          bad = {bad, " capture_response"};
        if (seen.read_valid !== want.row.read_valid) bad = {bad, " read_valid"};
        if (seen.read_value !== want.row.read_value) bad = {bad, " read_value"};
        if (seen.id_valid !== want.row.id_valid) bad = {bad, " id_valid"};
        if (seen.device_id !== want.row.device_id) bad = {bad, " device_id"};
        if (seen.operation_done !== want.row.operation_done) bad = {bad, " operation_done"};
        if (out_tlast !== want.last) bad = {bad, " last"};
        if (out_tdata[snfcs_pkg::OUT_DATA_W-1:$bits(snfcs_pkg::row_t)] !== '0)
          bad = {bad, " padding"};
        if (bad != "")
          note_failure($sformatf("result %0d:%s expected %h/%b got %h/%b", results_seen, bad,
                                 want.row, want.last, out_tdata, out_tlast));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  probe_t directed_items [$];

  task automatic plan(input logic [1:0] kind, input logic [3:0] op, input logic [23:0] addr,
                      input logic [15:0] cnt, input logic [7:0] db, input int n_typed,
                      input snfcs_pkg::row_t t0 = '0, input snfcs_pkg::row_t t1 = '0,
                      input snfcs_pkg::row_t t2 = '0);
    probe_t p;
    p.kind     = kind;
    p.op       = op;
    p.addr     = addr;
    p.cnt      = cnt;
    p.db       = db;
    p.n_typed  = n_typed;
    p.typed[0] = t0;
    p.typed[1] = t1;
    p.typed[2] = t2;
    directed_items.push_back(p);
  endtask

  initial begin : stimulus
    snfcs_pkg::row_t done_only;
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [23:0] addr;
    logic [15:0] cnt;
    logic [7:0]  db;

    done_only = host_row(1'b0, '0, 1'b0, '0, 1'b1);

    // stray items while idle are dropped
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'hA5, 0);
    plan(snfcs_pkg::KIND_PROGRAM, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h3C, 0);
    plan(KIND_UNUSED, OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 8'hFF, 0);
    // unknown opcode finishes at once
    plan(snfcs_pkg::KIND_REQUEST, OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 8'hFF, 1, done_only);
    // single-frame commands
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_WREN, 24'h0, 16'h0, 8'h00, 2,
         mosi_row(snfcs_pkg::OPC_WREN, 1'b1, 1'b0), done_only);
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_WRDI, 24'h0, 16'h0, 8'h00, 2,
         mosi_row(snfcs_pkg::OPC_WRDI, 1'b1, 1'b0), done_only);
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_WRSR, 24'h0, 16'h0, 8'hFF, 3,
         mosi_row(snfcs_pkg::OPC_WRSR, 1'b0, 1'b0), mosi_row(8'hFF, 1'b1, 1'b0), done_only);
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_POWER_DOWN, 24'h0, 16'h0, 8'h00, 2,
         mosi_row(snfcs_pkg::OPC_PD, 1'b1, 1'b0), done_only);
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_RELEASE, 24'h0, 16'h0, 8'h00, 2,
         mosi_row(snfcs_pkg::OPC_RPD, 1'b1, 1'b0), done_only);
    // status read and its reply
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_RDSR, 24'h0, 16'h0, 8'h00, -1);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h81, 1,
         host_row(1'b1, 8'h81, 1'b0, '0, 1'b1));
    // device id: high byte is held, low byte completes it
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h00, -1);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'hEF, 0);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h17, 1,
         host_row(1'b0, '0, 1'b1, 16'hEF17, 1'b1));
    // zero-length program and read at the top address
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_PROGRAM, 24'hFFFFFF, 16'h0000, 8'h00, 1,
         done_only);
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_READ, 24'hFFFFFF, 16'h0000, 8'h00, -1);
    // sector erase of the last index, a request while busy, busy and idle status
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_SECTOR_ERASE, 24'hFFFFFF, 16'h0, 8'h00, -1);
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_READ, 24'h000000, 16'hFFFF, 8'h00, 0);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h01, -1);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h00, -1);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h00, 1, done_only);
    // chip erase, busy bit clear with the other bits set
    plan(snfcs_pkg::KIND_REQUEST, snfcs_pkg::OP_CHIP_ERASE, 24'h0, 16'h0, 8'h00, -1);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'hFE, -1);
    plan(snfcs_pkg::KIND_FLASH, snfcs_pkg::OP_ID, 24'h0, 16'h0, 8'h00, 1, done_only);

    while (!rst_n) @(posedge clk);

    foreach (directed_items[i]) begin
      offer_item(directed_items[i].kind, directed_items[i].op, directed_items[i].addr,
                 directed_items[i].cnt, directed_items[i].db);
      predict_frames(directed_items[i].kind, directed_items[i].op, directed_items[i].addr,
                     directed_items[i].cnt, directed_items[i].db);
      expect_rows(directed_items[i].n_typed, directed_items[i].typed[0],
                  directed_items[i].typed[1], directed_items[i].typed[2]);
    end

    // random dialogues until the item budget is spent and the last op has ended
    while (items_accepted < TOTAL_ITEMS || seq_phase != snfcs_pkg::PH_IDLE) begin
      choose_item(kind, op, addr, cnt, db);
      offer_item(kind, op, addr, cnt, db);
      predict_frames(kind, op, addr, cnt, db);
      expect_rows(-1);
    end
    in_tvalid <= 1'b0;

    // drain, then keep watching to catch anything extra
    while (spi_rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input items, %0d result items checked, %0d host operations",
             items_accepted, results_seen, ops_started);
    $display("program pages %0d, busy status re-polls %0d, failures %0d",
             pages_opened, busy_repolls, fail_count);
    if (fail_count == 0) begin
      $display("PASS spi_nor_flash_command_sequencer");
    end else begin
      $display("FAIL spi_nor_flash_command_sequencer");
    end
    $finish;
  end

endmodule

// ----- spi_nor_flash_command_sequencer.f -----
src/snfcs_pkg.sv
src/snfcs_cmd.sv
src/snfcs_out.sv
src/spi_nor_flash_command_sequencer.sv
src/snfcs_checker.sv
test/tb_spi_nor_flash_command_sequencer.sv
